>>> rtl/csv_fp_pkg.sv
// ----------------------------------------------------------------------------
// CSV field parser package
// Shared constants, result kinds and the result record for the CSV field
// parser.
// ----------------------------------------------------------------------------
package csv_fp_pkg;

    localparam int MAX_FIELDS_DEF     = 32;
    localparam int FIELD_CAPACITY_DEF = 64;

    localparam logic [7:0] QUOTE_CH = 8'h22;
    localparam logic [7:0] COMMA_CH = 8'h2C;
    localparam logic [7:0] END_CH   = 8'h00;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_LINE  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [4:0] field_number;
        logic [5:0] char_position;
        logic [7:0] byte_out;
        logic [5:0] field_count;
    } t_result;

endpackage

>>> rtl/csv_fp_core.sv
// ----------------------------------------------------------------------------
// CSV field parser core
// Holds the line state (quote flags, field index, position, discard flag)
// and decodes one byte into at most one result.
// ----------------------------------------------------------------------------
module csv_fp_core #(
    parameter int MAX_FIELDS     = 32,
    parameter int FIELD_CAPACITY = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  logic [7:0]          i_byte,
    output logic                o_gen,
    output csv_fp_pkg::t_result o_result
);
    import csv_fp_pkg::*;

    localparam int FW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
    localparam int PW = $clog2(FIELD_CAPACITY);
    localparam logic [PW-1:0] POS_LAST = PW'(FIELD_CAPACITY - 1);
    localparam logic [FW:0]   FIELD_MAX = (FW + 1)'(MAX_FIELDS);

    logic          r_in_quotes, n_in_quotes;
    logic          r_pending, n_pending;
    logic [FW-1:0] r_field, n_field;
    logic [PW-1:0] r_pos, n_pos;
    logic          r_discard, n_discard;

    logic          do_unq;
    logic          do_store;
    logic          do_finish;
    logic [FW:0]   field_inc;
    logic [FW+4:0] field_wide;
    logic [PW+5:0] pos_wide;
    logic [FW+6:0] count_wide;

    assign field_inc  = {1'b0, r_field} + (FW + 1)'(1);
    assign field_wide = {5'b0, r_field};
    assign pos_wide   = {6'b0, r_pos};
    assign count_wide = {6'b0, field_inc};

    always_comb begin
        n_in_quotes = r_in_quotes;
        n_pending   = r_pending;
        n_field     = r_field;
        n_pos       = r_pos;
        n_discard   = r_discard;
        do_unq      = 1'b0;
        do_store    = 1'b0;
        do_finish   = 1'b0;
        o_gen       = 1'b0;
        o_result.kind          = KIND_CHAR;
        o_result.field_number  = field_wide[4:0];
        o_result.char_position = pos_wide[5:0];
        o_result.byte_out      = 8'h00;
        o_result.field_count   = 6'd0;

        if (r_discard) begin
            if (i_byte == END_CH) begin
                n_discard = 1'b0;
                n_in_quotes = 1'b0;
                n_pending = 1'b0;
                n_field = '0;
                n_pos = '0;
            end
        end else if (r_pending) begin
            n_pending = 1'b0;
            if (i_byte == QUOTE_CH) begin
                do_store = 1'b1;
            end else begin
                n_in_quotes = 1'b0;
                do_unq = 1'b1;
            end
        end else if (r_in_quotes) begin
            if (i_byte == END_CH) begin
                do_finish = 1'b1;
            end else if (i_byte == QUOTE_CH) begin
                n_pending = 1'b1;
            end else begin
                do_store = 1'b1;
            end
        end else begin
            do_unq = 1'b1;
        end

        if (do_unq) begin
            if (i_byte == QUOTE_CH) begin
                n_in_quotes = 1'b1;
            end else if (i_byte == COMMA_CH) begin
                o_gen = 1'b1;
                n_field = field_inc[FW-1:0];
                n_pos = '0;
                if (field_inc >= FIELD_MAX) begin
                    n_discard = 1'b1;
                    o_result.kind = KIND_LINE;
                    o_result.field_count = count_wide[5:0];
                end else begin
                    o_result.kind = KIND_CLOSE;
                end
            end else if (i_byte == END_CH) begin
                do_finish = 1'b1;
            end else begin
                do_store = 1'b1;
            end
        end

        if (do_store && (r_pos < POS_LAST)) begin
            o_gen = 1'b1;
            o_result.kind = KIND_CHAR;
            o_result.byte_out = i_byte;
            n_pos = r_pos + PW'(1);
        end

        if (do_finish) begin
            o_gen = 1'b1;
            o_result.kind = KIND_LINE;
            o_result.field_count = count_wide[5:0];
            n_in_quotes = 1'b0;
            n_pending = 1'b0;
            n_field = '0;
            n_pos = '0;
            n_discard = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quotes <= 1'b0;
            r_pending   <= 1'b0;
            r_field     <= '0;
            r_pos       <= '0;
            r_discard   <= 1'b0;
        end else if (i_advance) begin
            r_in_quotes <= n_in_quotes;
            r_pending   <= n_pending;
            r_field     <= n_field;
            r_pos       <= n_pos;
            r_discard   <= n_discard;
        end
    end

endmodule

>>> rtl/csv_field_parser.sv
// ----------------------------------------------------------------------------
// CSV field parser
// Splits a zero-terminated CSV line, one byte per transaction, into stored
// characters, field-close and line-end results with quoted-field handling.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while the input is not stalled and
// gives at most one result per byte. A byte goes into an input register,
// is decoded against the line state in the following cycle, and its result
// lands in an output register. The output register lets a new byte enter
// while a result still waits downstream; the input stalls only when a byte
// that produces a result finds the output register full and stalled.
module csv_field_parser #(
    parameter int MAX_FIELDS     = csv_fp_pkg::MAX_FIELDS_DEF,
    parameter int FIELD_CAPACITY = csv_fp_pkg::FIELD_CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_byte_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_result_kind,
    output logic [4:0] o_field_number,
    output logic [5:0] o_char_position,
    output logic [7:0] o_byte_out,
    output logic [5:0] o_field_count
);
    import csv_fp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_out_valid;
    t_result    r_result;

    logic       gen;
    t_result    result;
    logic       out_free;
    logic       advance;

    csv_fp_core #(
        .MAX_FIELDS     (MAX_FIELDS),
        .FIELD_CAPACITY (FIELD_CAPACITY)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_byte),
        .o_gen     (gen),
        .o_result  (result)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (!gen || out_free);
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || advance) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_in_valid || advance) begin
            r_byte <= i_byte_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && gen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && advance && gen) begin
            r_result <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_result.kind;
    assign o_field_number  = r_result.field_number;
    assign o_char_position = r_result.char_position;
    assign o_byte_out      = r_result.byte_out;
    assign o_field_count   = r_result.field_count;

endmodule
